[hw/rtl/ntc_lookup_pkg.sv]
// ----------------------------------------------------------------------------
// NTC lookup package
// Shared constants, register codes and the pipeline item type of the NTC
// thermistor table lookup core.
// ----------------------------------------------------------------------------
package ntc_lookup_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 128;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;

  // The bisection needs at most one step per halving plus one.
  localparam int SEARCH_STEPS = IDX_W + 1;

  // One table copy for the end-point reads and one per search step.
  localparam int NUM_COPIES = SEARCH_STEPS + 1;

  // Divider: 16 quotient bits, four per stage.
  localparam int DIV_STAGES = 4;
  localparam int DIV_BITS   = 16 / DIV_STAGES;

  // Stage map: prepare, divide, clamp, end points, search steps.
  localparam int ST_CLAMP = DIV_STAGES + 1;
  localparam int NUM_ST   = ST_CLAMP + 2 + SEARCH_STEPS;

  // Field widths.
  localparam int TEMP_W  = 7;
  localparam int IN_W    = 40;
  localparam int OUT_W   = 24;
  localparam int ADDR_W  = 4;

  // Register codes (word index of paddr).
  localparam logic [1:0] REG_ENTRIES = 2'd0;
  localparam logic [1:0] REG_RES_MAX = 2'd1;
  localparam logic [1:0] REG_RES_MIN = 2'd2;

  // Reset values of the registers.
  localparam logic [7:0]  ENTRIES_RST = 8'd101;
  localparam logic [15:0] RES_MAX_RST = 16'd40950;
  localparam logic [15:0] RES_MIN_RST = 16'd0;

  // One request as it travels down the pipeline.
  typedef struct packed {
    logic             func;
    logic             wen;
    logic [IDX_W-1:0] widx;
    logic [15:0]      wval;
    logic [15:0]      dvd;
    logic [12:0]      dvs;
    logic [12:0]      rem;
    logic [15:0]      quo;
    logic [15:0]      res_kohm;
    logic [CNT_W-1:0] lo;
    logic [CNT_W-1:0] hi;
    logic [IDX_W-1:0] mid;
    logic             active;
    logic [IDX_W-1:0] tidx;
  } item_t;

endpackage

[hw/rtl/ntc_temperature_table_lookup_core.sv]
// ----------------------------------------------------------------------------
// NTC temperature table lookup core
// Converts a 12-bit ADC sample into a clamped thermistor resistance and
// searches a descending resistance table for the temperature index.
// ----------------------------------------------------------------------------
// The core accepts one request per clock unless the output stalls and returns
// each conversion result; table writes give no result. The pipeline is a
// prepare stage, a four-stage radix-2 divider (four quotient bits per stage),
// a clamp stage, an end-point stage and eight bisection stages. Each search
// stage owns its own copy of the resistance table, and a table write travels
// down the pipeline and updates every copy as it passes, so each conversion
// sees exactly the writes that came before it. A stall at the output holds
// the whole pipeline. The table has no reset and must be written before use.
module ntc_temperature_table_lookup_core
  import ntc_lookup_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // Input stream.
  input  logic              s_tvalid,
  output logic              s_tready,
  // [6:0] table_index, [22:7] table_value, [34:23] adc_sample, zero pad.
  input  logic [IN_W-1:0]   s_tdata,
  // [0] func.
  input  logic              s_tuser,
  // Result stream.
  output logic              m_tvalid,
  input  logic              m_tready,
  // [6:0] temperature_index, [22:7] resistance_kohm, zero pad.
  output logic [OUT_W-1:0]  m_tdata,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // Configuration registers.
  logic [7:0]  entries_in_use;
  logic [15:0] resistance_max;
  logic [15:0] resistance_min;

  // Pipeline.
  item_t             stage      [NUM_ST];
  item_t             stage_next [NUM_ST];
  logic [NUM_ST-1:0] stage_vld;
  logic              advance;
  logic [CNT_W-1:0]  n_eff;

  // Table copies and their read ports.
  logic [15:0]      tbl_mem [NUM_COPIES][TABLE_DEPTH];
  logic [15:0]      rd_a    [NUM_COPIES];
  logic [15:0]      rd_b    [NUM_COPIES];
  logic [IDX_W-1:0] addr_a  [NUM_COPIES];
  logic [IDX_W-1:0] addr_b  [NUM_COPIES];

  // Four restoring division steps.
  function automatic item_t div_step(item_t p);
    item_t       q;
    logic [13:0] rem_sh;
    q = p;
    for (int i = 0; i < DIV_BITS; i++) begin
      rem_sh = {q.rem, q.dvd[15]};
      q.dvd  = {q.dvd[14:0], 1'b0};
      if (rem_sh >= {1'b0, q.dvs}) begin
        q.rem = 13'(rem_sh - {1'b0, q.dvs});
        q.quo = {q.quo[14:0], 1'b1};
      end else begin
        q.rem = rem_sh[12:0];
        q.quo = {q.quo[14:0], 1'b0};
      end
    end
    return q;
  endfunction

  // End-point checks against the last and the first entry.
  function automatic item_t eval_ends(item_t p, logic [15:0] last_v, logic [15:0] first_v,
                                      logic [CNT_W-1:0] n);
    item_t            q;
    logic [CNT_W-1:0] nm1;
    q   = p;
    nm1 = n - 1'b1;
    q.lo     = '0;
    q.hi     = nm1;
    q.mid    = IDX_W'(nm1 >> 1);
    q.active = 1'b0;
    if (p.func) begin
      if (p.res_kohm <= last_v) begin
        q.tidx = IDX_W'(nm1);
      end else if (p.res_kohm >= first_v) begin
        q.tidx = '0;
      end else begin
        q.active = 1'b1;
      end
    end
    return q;
  endfunction

  // One bisection step.
  function automatic item_t eval_step(item_t p, logic [15:0] here, logic [15:0] nxt,
                                      logic [CNT_W-1:0] n);
    item_t            q;
    logic [CNT_W-1:0] mid_ext;
    q       = p;
    mid_ext = {1'b0, p.mid};
    if (p.func && p.active) begin
      if ((mid_ext + 1'b1 < n) && (p.res_kohm <= here) && (p.res_kohm >= nxt)) begin
        q.tidx   = p.mid;
        q.active = 1'b0;
      end else begin
        if (p.res_kohm < here) begin
          q.lo = mid_ext + 1'b1;
        end else if (p.mid == '0) begin
          q.active = 1'b0;
        end else begin
          q.hi = mid_ext - 1'b1;
        end
        if (q.active && (q.lo > q.hi)) begin
          q.active = 1'b0;
        end
      end
      q.mid = IDX_W'((q.lo + q.hi) >> 1);
    end
    return q;
  endfunction

  // Effective entry count: at least one, at most the table depth.
  always_comb begin
    if (entries_in_use == 8'd0) begin
      n_eff = CNT_W'(1);
    end else if ({24'd0, entries_in_use} > 32'(TABLE_DEPTH)) begin
      n_eff = CNT_W'(TABLE_DEPTH);
    end else begin
      n_eff = CNT_W'(entries_in_use);
    end
  end

  // The whole pipeline moves unless a result waits at the output.
  assign advance  = !stage_vld[NUM_ST-1] || !stage[NUM_ST-1].func || m_tready;
  assign s_tready = advance;

  // Next value of every stage.
  always_comb begin
    item_t in_item;
    logic [15:0] adc_ext;
    adc_ext = {4'd0, s_tdata[34:23]};
    in_item          = '0;
    in_item.func     = s_tuser;
    in_item.wen      = !s_tuser && ({25'd0, s_tdata[6:0]} < 32'(TABLE_DEPTH));
    in_item.widx     = IDX_W'(s_tdata[6:0]);
    in_item.wval     = s_tdata[22:7];
    in_item.dvd      = (adc_ext << 3) + (adc_ext << 1);
    in_item.dvs      = 13'd4096 - {1'b0, s_tdata[34:23]};
    stage_next[0]    = in_item;
    for (int k = 1; k <= DIV_STAGES; k++) begin
      stage_next[k] = div_step(stage[k-1]);
    end
    // Clamp: maximum first, minimum last.
    stage_next[ST_CLAMP] = stage[ST_CLAMP-1];
    stage_next[ST_CLAMP].res_kohm = stage[ST_CLAMP-1].quo;
    if (stage_next[ST_CLAMP].res_kohm > resistance_max) begin
      stage_next[ST_CLAMP].res_kohm = resistance_max;
    end
    if (stage_next[ST_CLAMP].res_kohm < resistance_min) begin
      stage_next[ST_CLAMP].res_kohm = resistance_min;
    end
    stage_next[ST_CLAMP+1] = eval_ends(stage[ST_CLAMP], rd_a[0], rd_b[0], n_eff);
    for (int i = 1; i <= SEARCH_STEPS; i++) begin
      stage_next[ST_CLAMP+1+i] = eval_step(stage[ST_CLAMP+i], rd_a[i], rd_b[i], n_eff);
    end
  end

  // Read addresses: end points for the first copy, then mid and mid+1.
  always_comb begin
    addr_a[0] = IDX_W'(n_eff - 1'b1);
    addr_b[0] = '0;
    for (int j = 1; j < NUM_COPIES; j++) begin
      addr_a[j] = stage_next[ST_CLAMP+j].mid;
      addr_b[j] = stage_next[ST_CLAMP+j].mid + 1'b1;
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld <= '0;
    end else if (advance) begin
      stage_vld <= {stage_vld[NUM_ST-2:0], s_tvalid};
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < NUM_ST; k++) begin
        stage[k] <= stage_next[k];
      end
    end
  end

  // Table copies: a write updates each copy as it passes the stage that reads it.
  for (genvar j = 0; j < NUM_COPIES; j++) begin : g_copy
    always_ff @(posedge clk) begin
      if (advance && stage_vld[ST_CLAMP-1+j]) begin
        if (stage[ST_CLAMP-1+j].wen) begin
          tbl_mem[j][stage[ST_CLAMP-1+j].widx] <= stage[ST_CLAMP-1+j].wval;
        end
        rd_a[j] <= tbl_mem[j][addr_a[j]];
        rd_b[j] <= tbl_mem[j][addr_b[j]];
      end
    end
  end

  // Result output.
  assign m_tvalid = stage_vld[NUM_ST-1] && stage[NUM_ST-1].func;
  assign m_tdata  = {1'b0, stage[NUM_ST-1].res_kohm, TEMP_W'(stage[NUM_ST-1].tidx)};

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= ENTRIES_RST;
      resistance_max <= RES_MAX_RST;
      resistance_min <= RES_MIN_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_ENTRIES: entries_in_use <= pwdata[7:0];
        REG_RES_MAX: resistance_max <= pwdata[15:0];
        REG_RES_MIN: resistance_min <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Configuration reads.
  always_comb begin
    case (paddr[3:2])
      REG_ENTRIES: prdata = {24'd0, entries_in_use};
      REG_RES_MAX: prdata = {16'd0, resistance_max};
      REG_RES_MIN: prdata = {16'd0, resistance_min};
      default:     prdata = '0;
    endcase
  end

  assign pready = 1'b1;

endmodule
